[rtl/lhl_pkg.sv]
// ----------------------------------------------------------------------------
// lhl_pkg
// Shared types, widths and constants for the light average hysteresis block.
// ----------------------------------------------------------------------------
package lhl_pkg;

   localparam int WINDOW   = 50;
   localparam int SAMPLE_W = 12;
   localparam int NUM_REGS = 8;
   localparam int REG_W    = 12;
   localparam int CNT_W    = $clog2(WINDOW + 1);
   localparam int IDX_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_W    = SAMPLE_W + CNT_W;
   localparam int STEP_W   = $clog2(SAMPLE_W + 1);
   localparam int CSR_IDX_W = $clog2(NUM_REGS);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_L3_TO_2_ABOVE = 3'd0,
      REG_L2_TO_3_BELOW = 3'd1,
      REG_L2_TO_1_ABOVE = 3'd2,
      REG_L1_TO_2_BELOW = 3'd3,
      REG_L1_TO_0_ABOVE = 3'd4,
      REG_L0_TO_1_BELOW = 3'd5,
      REG_BLIND_CLOSE   = 3'd6,
      REG_BLIND_OPEN    = 3'd7
   } reg_idx_type;

   localparam logic [REG_W-1:0] THR_RESET [NUM_REGS] = '{
      12'd550, 12'd450, 12'd850, 12'd750, 12'd1250, 12'd1150, 12'd1700, 12'd1200
   };

   typedef logic [REG_W-1:0] thr_type [NUM_REGS];

   localparam logic [1:0] LVL_0 = 2'd0;
   localparam logic [1:0] LVL_1 = 2'd1;
   localparam logic [1:0] LVL_2 = 2'd2;
   localparam logic [1:0] LVL_3 = 2'd3;

   localparam logic [1:0] MOVE_NONE  = 2'd0;
   localparam logic [1:0] MOVE_PLUS  = 2'd1;
   localparam logic [1:0] MOVE_MINUS = 2'd2;

   typedef struct packed {
      logic                start;
      logic [SUM_W-1:0]    dividend;
      logic [CNT_W-1:0]    divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [SAMPLE_W-1:0] quotient;
   } div_sts_type;

   function automatic logic [1:0] next_level(input logic [1:0] lvl,
                                             input logic [SAMPLE_W-1:0] avg,
                                             input thr_type thr);
      logic [1:0] nl;
      begin
         nl = lvl;
         unique case (lvl)
            LVL_3: begin
               if (avg > thr[REG_L3_TO_2_ABOVE]) nl = LVL_2;
            end
            LVL_2: begin
               if (avg < thr[REG_L2_TO_3_BELOW]) nl = LVL_3;
               else if (avg > thr[REG_L2_TO_1_ABOVE]) nl = LVL_1;
            end
            LVL_1: begin
               if (avg < thr[REG_L1_TO_2_BELOW]) nl = LVL_2;
               else if (avg > thr[REG_L1_TO_0_ABOVE]) nl = LVL_0;
            end
            LVL_0: begin
               if (avg < thr[REG_L0_TO_1_BELOW]) nl = LVL_1;
            end
            default: nl = lvl;
         endcase
         return nl;
      end
   endfunction

endpackage

[rtl/lhl_if.sv]
// ----------------------------------------------------------------------------
// lhl_if
// Valid/ready channels for light samples and for level results.
// ----------------------------------------------------------------------------
interface lhl_req_if import lhl_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] light_sample;
   logic                emergency;

   modport source (output valid, output light_sample, output emergency, input ready);
   modport sink (input valid, input light_sample, input emergency, output ready);
endinterface

interface lhl_rsp_if import lhl_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] average;
   logic [1:0]          led_level;
   logic                blind_state;
   logic [1:0]          blind_move;

   modport source (output valid, output average, output led_level,
                   output blind_state, output blind_move, input ready);
   modport sink (input valid, input average, input led_level,
                 input blind_state, input blind_move, output ready);
endinterface

[rtl/lhl_div.sv]
// ----------------------------------------------------------------------------
// lhl_div
// Restoring divider, one quotient bit per cycle, for sum over sample count.
// ----------------------------------------------------------------------------
module lhl_div import lhl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_sts_type div_sts
);

   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [SAMPLE_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]    den_ff;
   logic [STEP_W-1:0]   cnt_ff;
   logic                busy_ff;
   logic                done_ff;
   logic [CNT_W:0]      trial;
   logic [CNT_W:0]      diff;
   logic                fits;

   // quotient fits in sample width since the average never exceeds a sample
   always_comb begin
      trial  = {rem_ff, quo_ff[SAMPLE_W-1]};
      diff   = trial - {1'b0, den_ff};
      fits   = (trial >= {1'b0, den_ff});
      rem_in = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_in = {quo_ff[SAMPLE_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == STEP_W'(1));
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= STEP_W'(SAMPLE_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - STEP_W'(1);
            if (cnt_ff == STEP_W'(1)) busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff <= div_req.dividend[SUM_W-1:SAMPLE_W];
         quo_ff <= div_req.dividend[SAMPLE_W-1:0];
         den_ff <= div_req.divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign div_sts.done     = done_ff;
   assign div_sts.quotient = quo_ff;

endmodule

[rtl/light_average_hysteresis_levels.sv]
// ----------------------------------------------------------------------------
// light_average_hysteresis_levels
// Boxcar moving average of light samples with hysteresis LED and blind levels.
// ----------------------------------------------------------------------------
// Flow: a normal sample passes the ring update and sum, the 12-step serial
// divider, 1 to 3 LED steps, the blind step and the output register; an
// emergency sample goes from idle straight to the done state and the output
// register. A new sample is taken only in idle, after the last result is registered.
// Reset clears the state and loads the reset thresholds; the sample ring is not
// cleared, slots past the fill count read as zero.
module light_average_hysteresis_levels import lhl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   lhl_req_if.sink              req,
   lhl_rsp_if.source            rsp,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_wdata
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_SUM   = 6'b000010,
      S_DIV   = 6'b000100,
      S_LEVEL = 6'b001000,
      S_BLIND = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   thr_type             thr_ff;
   logic [SAMPLE_W-1:0] ring [WINDOW];
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [IDX_W-1:0]    wr_idx_ff;
   logic [CNT_W-1:0]    filled_ff, filled_in;
   logic [SAMPLE_W-1:0] avg_ff;
   logic [1:0]          level_ff;
   logic                blind_ff;
   logic [1:0]          move_ff;
   logic [1:0]          iter_ff;
   logic [SAMPLE_W-1:0] old_sample;
   logic [1:0]          nl;
   logic                blind_target;
   logic                req_xfer;
   logic                rsp_free;
   logic                rsp_valid_ff;
   logic [SAMPLE_W-1:0] rsp_avg_ff;
   logic [1:0]          rsp_level_ff;
   logic                rsp_blind_ff;
   logic [1:0]          rsp_move_ff;
   div_req_type         div_req;
   div_sts_type         div_sts;

   assign req.ready = (state_ff == S_IDLE);
   assign req_xfer  = req.valid && req.ready;
   assign rsp_free  = !rsp_valid_ff || rsp.ready;

   always_comb begin
      old_sample = (filled_ff < CNT_W'(WINDOW)) ? '0 : rd_data_ff;
      sum_in     = sum_ff - SUM_W'(old_sample) + SUM_W'(sample_ff);
      filled_in  = (filled_ff < CNT_W'(WINDOW)) ? filled_ff + CNT_W'(1) : filled_ff;
      nl         = next_level(level_ff, avg_ff, thr_ff);
      blind_target = blind_ff;
      if (avg_ff > thr_ff[REG_BLIND_CLOSE]) blind_target = 1'b1;
      else if (avg_ff < thr_ff[REG_BLIND_OPEN]) blind_target = 1'b0;
      div_req.start    = (state_ff == S_SUM);
      div_req.dividend = sum_in;
      div_req.divisor  = filled_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) state_in = req.emergency ? S_DONE : S_SUM;
         end
         S_SUM: state_in = S_DIV;
         S_DIV: begin
            if (div_sts.done) state_in = S_LEVEL;
         end
         S_LEVEL: begin
            if (nl == level_ff || iter_ff == 2'd2) state_in = S_BLIND;
         end
         S_BLIND: state_in = S_DONE;
         S_DONE: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   lhl_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_sts (div_sts)
   );

   // sample ring
   always_ff @(posedge clock) begin
      rd_data_ff <= ring[wr_idx_ff];
      if (state_ff == S_SUM) ring[wr_idx_ff] <= sample_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         wr_idx_ff    <= '0;
         filled_ff    <= '0;
         avg_ff       <= '0;
         level_ff     <= LVL_0;
         blind_ff     <= 1'b0;
         move_ff      <= MOVE_NONE;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_REGS; i++) thr_ff[i] <= THR_RESET[i];
      end else begin
         state_ff <= state_in;
         if (csr_we) thr_ff[csr_index] <= csr_wdata;
         if (state_ff == S_DONE && rsp_free) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               move_ff <= MOVE_NONE;
               iter_ff <= '0;
            end
            S_SUM: begin
               sum_ff    <= sum_in;
               filled_ff <= filled_in;
               wr_idx_ff <= (wr_idx_ff == IDX_W'(WINDOW - 1)) ? '0 : wr_idx_ff + IDX_W'(1);
            end
            S_DIV: begin
               if (div_sts.done) avg_ff <= div_sts.quotient;
            end
            S_LEVEL: begin
               level_ff <= nl;
               iter_ff  <= iter_ff + 2'd1;
            end
            S_BLIND: begin
               blind_ff <= blind_target;
               if (blind_target != blind_ff) move_ff <= blind_target ? MOVE_PLUS : MOVE_MINUS;
            end
            S_DONE: ;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) sample_ff <= req.light_sample;
      if (state_ff == S_DONE && rsp_free) begin
         rsp_avg_ff   <= avg_ff;
         rsp_level_ff <= level_ff;
         rsp_blind_ff <= blind_ff;
         rsp_move_ff  <= move_ff;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.average     = rsp_avg_ff;
   assign rsp.led_level   = rsp_level_ff;
   assign rsp.blind_state = rsp_blind_ff;
   assign rsp.blind_move  = rsp_move_ff;

endmodule

[rtl/lhl_checker.sv]
// ----------------------------------------------------------------------------
// lhl_checker
// Port-level checks on the light average hysteresis block, bound to the top.
// ----------------------------------------------------------------------------
module lhl_checker import lhl_pkg::*; (
   input logic       clock,
   input logic       reset,
   lhl_req_if.sink   req,
   lhl_rsp_if.source rsp
);

   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.average)
         && $stable(rsp.led_level) && $stable(rsp.blind_state) && $stable(rsp.blind_move))
      else $error("stalled result changed");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready)
      else $error("sample taken while one is in work");

   a_move_code: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.blind_move != MOVE_MINUS + 2'd1)
      else $error("undefined blind move code");

   a_move_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.blind_move == MOVE_PLUS |-> rsp.blind_state)
      else $error("blind lowered without close state");

endmodule

bind light_average_hysteresis_levels lhl_checker u_lhl_checker (
   .clock (clock),
   .reset (reset),
   .req   (req),
   .rsp   (rsp)
);

[dv/tb_light_average_hysteresis_levels.sv]
// ----------------------------------------------------------------------------
// tb_light_average_hysteresis_levels
// Self-checking bench for the light average block. Light samples go in on the
// request channel and a local model of the moving average, the LED hysteresis
// levels and the blind state forms the expected responses. Each response is
// compared field by field in order. The run steps through several threshold
// settings, including all-zero, all-max and crossed thresholds. Both channels
// idle at random outside the steady phase, and the response side holds off for long stretches.
// ----------------------------------------------------------------------------
module tb_light_average_hysteresis_levels;
   import lhl_pkg::*;

   localparam int QUIET_LIMIT  = 3000;
   localparam int SETTLE_GAP   = 24;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 147;
   localparam int NUM_PHASES   = 8;
   localparam int STEADY_PHASE = 3;

   typedef struct packed {
      logic [SAMPLE_W-1:0] average;
      logic [1:0]          led_level;
      logic                blind_state;
      logic [1:0]          blind_move;
   } light_result_t;

   class level_tracker;
      thr_type             thr;
      logic [SAMPLE_W-1:0] ring [WINDOW];
      logic [SUM_W-1:0]    sum;
      int unsigned         wr_pos;
      int unsigned         fill;
      logic [SAMPLE_W-1:0] avg;
      logic [1:0]          level;
      logic                blind;
      light_result_t       pending_levels [$];
      int                  errors;
      int                  n_samples;
      int                  n_held;
      int                  n_checked;
      int                  n_moves;

      function new();
         thr = THR_RESET;
         foreach (ring[i]) ring[i] = '0;
         sum = '0;
         wr_pos = 0;
         fill = 0;
         avg = '0;
         level = LVL_0;
         blind = 1'b0;
         errors = 0;
         n_samples = 0;
         n_held = 0;
         n_checked = 0;
         n_moves = 0;
      endfunction

      function void set_thresholds(input thr_type t);
         thr = t;
      endfunction

      function logic [1:0] level_after(input logic [1:0] lvl);
         case (lvl)
            LVL_3: begin
               if (avg > thr[REG_L3_TO_2_ABOVE]) return LVL_2;
            end
            LVL_2: begin
               if (avg < thr[REG_L2_TO_3_BELOW]) return LVL_3;
               if (avg > thr[REG_L2_TO_1_ABOVE]) return LVL_1;
            end
            LVL_1: begin
               if (avg < thr[REG_L1_TO_2_BELOW]) return LVL_2;
               if (avg > thr[REG_L1_TO_0_ABOVE]) return LVL_0;
            end
            default: begin
               if (avg < thr[REG_L0_TO_1_BELOW]) return LVL_1;
            end
         endcase
         return lvl;
      endfunction

      function void take_sample(input logic [SAMPLE_W-1:0] sample, input logic emerg);
         light_result_t r;
         logic [1:0]    nl;
         logic          target;
         r.blind_move = MOVE_NONE;
         n_samples++;
         if (emerg) begin
            n_held++;
         end else begin
            sum = sum - SUM_W'(ring[wr_pos]) + SUM_W'(sample);
            ring[wr_pos] = sample;
            wr_pos = (wr_pos + 1 == WINDOW) ? 0 : wr_pos + 1;
            if (fill < WINDOW) fill++;
            avg = SAMPLE_W'(sum / fill);
            // crossed thresholds can bounce the level, so at most three steps
            for (int s = 0; s < 3; s++) begin
               nl = level_after(level);
               if (nl == level) break;
               level = nl;
            end
            // close wins when both blind conditions hold
            target = blind;
            if (avg > thr[REG_BLIND_CLOSE]) target = 1'b1;
            else if (avg < thr[REG_BLIND_OPEN]) target = 1'b0;
            if (target != blind) begin
               r.blind_move = target ? MOVE_PLUS : MOVE_MINUS;
               blind = target;
               n_moves++;
            end
         end
         r.average = avg;
         r.led_level = level;
         r.blind_state = blind;
         pending_levels.push_back(r);
      endfunction

      function void compare_field(input string field, input logic [SAMPLE_W-1:0] want,
                                  input logic [SAMPLE_W-1:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
         end
      endfunction

      function void match_result(input light_result_t got);
         light_result_t want;
         n_checked++;
         if (pending_levels.size() == 0) begin
            errors++;
            $display("%0t: response with nothing expected, expected none actual avg %0d",
                     $time, got.average);
            return;
         end
         want = pending_levels.pop_front();
         compare_field("average", want.average, got.average);
         compare_field("led_level", SAMPLE_W'(want.led_level), SAMPLE_W'(got.led_level));
         compare_field("blind_state", SAMPLE_W'(want.blind_state), SAMPLE_W'(got.blind_state));
         compare_field("blind_move", SAMPLE_W'(want.blind_move), SAMPLE_W'(got.blind_move));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [REG_W-1:0]     csr_wdata;

   lhl_req_if req_if ();
   lhl_rsp_if rsp_if ();

   level_tracker tracker;
   logic steady = 1'b0;
   int   quiet_cycles = 0;
   int   n_settings = 0;
   int   trend_target = 0;
   int   trend_noise = 0;

   light_average_hysteresis_levels dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // transfer monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            tracker.take_sample(req_if.light_sample, req_if.emergency);
         if (rsp_if.valid && rsp_if.ready)
            tracker.match_result(light_result_t'{rsp_if.average, rsp_if.led_level,
                                                 rsp_if.blind_state, rsp_if.blind_move});
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("tb_light_average_hysteresis_levels: errors");
            $finish;
         end
      end
   end

   // response side: random idling plus long hold-offs
   initial begin : receiver
      int taken;
      taken = 0;
      rsp_if.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_if.valid && rsp_if.ready) begin
            taken++;
            if (taken % 400 == 150) begin
               rsp_if.ready <= 1'b0;
               repeat (HOLD_CYCLES) @(posedge clock);
            end
         end
         rsp_if.ready <= steady || ($urandom_range(99) >= 37);
         @(posedge clock);
      end
   end

   task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input logic emerg);
      while (!steady && $urandom_range(99) < 37) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.light_sample <= sample;
      req_if.emergency <= emerg;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic wait_idle();
      @(posedge clock);
      while (tracker.pending_levels.size() != 0) @(posedge clock);
      repeat (SETTLE_GAP) @(posedge clock);
   endtask

   task automatic write_thresholds(input thr_type t);
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_we <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= t[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      tracker.set_thresholds(t);
      n_settings++;
   endtask

   function automatic thr_type make_thresholds(input int phase);
      thr_type t;
      int      b;
      int      h;
      case (phase)
         1: t = '{default: 12'h000};
         2: t = '{default: 12'hFFF};
         3: begin
            b = $urandom_range(0, 600);
            h = $urandom_range(0, 150);
            t[REG_L2_TO_3_BELOW] = REG_W'(b);
            t[REG_L3_TO_2_ABOVE] = REG_W'(b + h);
            b = b + h + $urandom_range(50, 600);
            t[REG_L1_TO_2_BELOW] = REG_W'(b);
            t[REG_L2_TO_1_ABOVE] = REG_W'(b + h);
            b = b + h + $urandom_range(50, 600);
            t[REG_L0_TO_1_BELOW] = REG_W'(b);
            t[REG_L1_TO_0_ABOVE] = REG_W'(b + h);
            b = $urandom_range(0, 2000);
            t[REG_BLIND_OPEN] = REG_W'(b);
            t[REG_BLIND_CLOSE] = REG_W'(b + $urandom_range(0, 1500));
         end
         4: begin
            // crossed pairs make the level bounce; blind conditions overlap
            t[REG_L3_TO_2_ABOVE] = REG_W'($urandom_range(0, 300));
            t[REG_L2_TO_3_BELOW] = REG_W'($urandom_range(3000, 4095));
            t[REG_L2_TO_1_ABOVE] = REG_W'($urandom_range(0, 300));
            t[REG_L1_TO_2_BELOW] = REG_W'($urandom_range(3000, 4095));
            t[REG_L1_TO_0_ABOVE] = REG_W'($urandom_range(0, 300));
            t[REG_L0_TO_1_BELOW] = REG_W'($urandom_range(3000, 4095));
            t[REG_BLIND_CLOSE] = REG_W'($urandom_range(0, 1000));
            t[REG_BLIND_OPEN] = REG_W'($urandom_range(3000, 4095));
         end
         5, 6: foreach (t[i]) t[i] = REG_W'($urandom_range(0, 4095));
         default: t = THR_RESET;
      endcase
      return t;
   endfunction

   function automatic logic [SAMPLE_W-1:0] trend_sample();
      int v;
      v = trend_target + int'($urandom_range(0, 2 * trend_noise)) - trend_noise;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return SAMPLE_W'(v);
   endfunction

   task automatic run_phase(input int phase, input int n_items);
      int seg_left;
      int pick;
      seg_left = 0;
      wait_idle();
      write_thresholds(make_thresholds(phase));
      steady = (phase == STEADY_PHASE);
      for (int k = 0; k < n_items; k++) begin
         if (seg_left == 0) begin
            pick = $urandom_range(0, 2);
            trend_target = $urandom_range(0, 4095);
            trend_noise = (pick == 0) ? 0 : (pick == 1) ? 40 : 300;
            seg_left = $urandom_range(30, 70);
         end
         seg_left--;
         pick = $urandom_range(99);
         if (pick < 9)
            send_sample(12'($urandom), 1'b1);
         else if (pick < 19)
            send_sample(12'($urandom), 1'b0);
         else
            send_sample(trend_sample(), 1'b0);
      end
      req_if.valid <= 1'b0;
      steady = 1'b0;
   endtask

   initial begin : stimulus
      tracker = new;
      req_if.valid = 1'b0;
      req_if.light_sample = '0;
      req_if.emergency = 1'b0;
      csr_we = 1'b0;
      csr_index = REG_L3_TO_2_ABOVE;
      csr_wdata = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // held samples before anything is stored, then level and blind sweeps
      send_sample(12'hFFF, 1'b1);
      send_sample(12'h000, 1'b1);
      send_sample(12'h000, 1'b0);
      send_sample(12'hFFF, 1'b0);
      send_sample(12'hFFF, 1'b0);
      send_sample(12'hAAA, 1'b1);
      send_sample(12'hFFF, 1'b0);
      repeat (6) send_sample(12'h000, 1'b0);
      send_sample(12'h555, 1'b0);
      send_sample(12'hAAA, 1'b0);
      send_sample(12'h800, 1'b0);
      send_sample(12'h7FF, 1'b0);
      send_sample(12'h001, 1'b0);
      send_sample(12'h555, 1'b1);
      repeat (3) send_sample(12'hFFF, 1'b0);
      req_if.valid <= 1'b0;

      for (int p = 0; p < NUM_PHASES; p++)
         run_phase(p, PHASE_ITEMS);
      wait_idle();

      $display("run: %0d samples sent (%0d held for emergency), %0d responses checked",
               tracker.n_samples, tracker.n_held, tracker.n_checked);
      $display("run: %0d threshold settings incl. all-zero, all-max and crossed, %0d blind moves",
               n_settings, tracker.n_moves);
      if (tracker.errors == 0 && tracker.pending_levels.size() == 0)
         $display("tb_light_average_hysteresis_levels: clean");
      else
         $display("tb_light_average_hysteresis_levels: errors");
      $finish;
   end

endmodule
